[rtl/u16u8_pkg.sv]
// Package for the UTF-16 unit to UTF-8 byte encoder.
// Holds the queue item and head types and the encoding constants; no dependencies.
package u16u8_pkg;

    // Range limits for the one- and two-byte forms
    localparam logic [15:0] ONE_BYTE_LIMIT = 16'h0080;
    localparam logic [15:0] TWO_BYTE_LIMIT = 16'h0800;

    // Ligature code points that expand to ASCII letter runs
    localparam logic [15:0] LIG_FF  = 16'hFB00;
    localparam logic [15:0] LIG_FI  = 16'hFB01;
    localparam logic [15:0] LIG_FL  = 16'hFB02;
    localparam logic [15:0] LIG_FFI = 16'hFB03;
    localparam logic [15:0] LIG_FFL = 16'hFB04;

    // ASCII letters used by the ligatures
    localparam logic [7:0] ASCII_F = 8'h66;
    localparam logic [7:0] ASCII_I = 8'h69;
    localparam logic [7:0] ASCII_L = 8'h6C;

    // Lead and continuation byte markers
    localparam logic [2:0] LEAD2_TAG = 3'b110;
    localparam logic [3:0] LEAD3_TAG = 4'b1110;
    localparam logic [1:0] CONT_TAG  = 2'b10;

    // Index of the final byte of a sequence
    localparam logic [1:0] LAST_IDX_1 = 2'd0;
    localparam logic [1:0] LAST_IDX_2 = 2'd1;
    localparam logic [1:0] LAST_IDX_3 = 2'd2;

    // One classified code point: up to three bytes plus index of the last
    typedef struct packed {
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
        logic [1:0] last_idx;
    } u16u8_item_t;

    // Head of the queue as seen by the back end
    typedef struct packed {
        logic        valid;
        u16u8_item_t item;
    } u16u8_head_t;

endpackage

[rtl/utf16_unit_to_utf8_bytes.sv]
// Top level of the UTF-16 unit to UTF-8 byte encoder.
// Instantiates u16u8_front, u16u8_queue and u16u8_back; uses u16u8_pkg.
//
// Usage:
//   Input channel (s_valid/s_ready/s_code_point) takes one 16-bit code unit
//   per transfer. Output channel (m_valid/m_ready/m_out_byte/m_last) gives
//   its bytes in order, m_last high on the final byte of each unit.
//   Units below 0x80 give one byte, below 0x800 two, others three; the
//   ligatures U+FB00..U+FB04 give their ASCII letter runs.
//   The first byte passes through a queue entry and then the output
//   register. Throughput: one byte per cycle while m_ready is high, set
//   by the byte-wide output register.
//   The front end classifies a unit in the cycle it is accepted and writes
//   it into a QUEUE_DEPTH-entry queue; s_ready is low only while the queue
//   is full. The back end drains the queue head into the output register.
//   When the receiver stalls, the output byte holds, then the queue fills
//   and s_ready drops. Reset empties the queue and clears m_valid.
module utf16_unit_to_utf8_bytes #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_code_point,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_last
);

    u16u8_pkg::u16u8_item_t front_item;
    u16u8_pkg::u16u8_head_t queue_head;
    logic                   queue_full;
    logic                   queue_pop;

    u16u8_front u_front (
        .code_point (s_code_point),
        .item       (front_item)
    );

    u16u8_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_valid),
        .push_item (front_item),
        .full      (queue_full),
        .pop       (queue_pop),
        .head      (queue_head)
    );

    u16u8_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (queue_head),
        .pop        (queue_pop),
        .m_out_byte (m_out_byte),
        .m_last     (m_last),
        .m_valid    (m_valid),
        .m_ready    (m_ready)
    );

    assign s_ready = !queue_full;

endmodule

[rtl/u16u8_front.sv]
// Front end: classifies one code point into its byte sequence.
// Depends on u16u8_pkg.
module u16u8_front (
    input  logic [15:0]           code_point,
    output u16u8_pkg::u16u8_item_t item
);

    // Pick the encoding form and build all bytes at once
    always_comb begin
        item.byte0    = 8'h00;
        item.byte1    = 8'h00;
        item.byte2    = 8'h00;
        item.last_idx = u16u8_pkg::LAST_IDX_3;
        if (code_point < u16u8_pkg::ONE_BYTE_LIMIT) begin
            item.byte0    = code_point[7:0];
            item.last_idx = u16u8_pkg::LAST_IDX_1;
        end else if (code_point < u16u8_pkg::TWO_BYTE_LIMIT) begin
            item.byte0    = {u16u8_pkg::LEAD2_TAG, code_point[10:6]};
            item.byte1    = {u16u8_pkg::CONT_TAG, code_point[5:0]};
            item.last_idx = u16u8_pkg::LAST_IDX_2;
        end else if (code_point == u16u8_pkg::LIG_FF) begin
            item.byte0    = u16u8_pkg::ASCII_F;
            item.byte1    = u16u8_pkg::ASCII_F;
            item.last_idx = u16u8_pkg::LAST_IDX_2;
        end else if (code_point == u16u8_pkg::LIG_FI) begin
            item.byte0    = u16u8_pkg::ASCII_F;
            item.byte1    = u16u8_pkg::ASCII_I;
            item.last_idx = u16u8_pkg::LAST_IDX_2;
        end else if (code_point == u16u8_pkg::LIG_FL) begin
            item.byte0    = u16u8_pkg::ASCII_F;
            item.byte1    = u16u8_pkg::ASCII_L;
            item.last_idx = u16u8_pkg::LAST_IDX_2;
        end else if (code_point == u16u8_pkg::LIG_FFI) begin
            item.byte0    = u16u8_pkg::ASCII_F;
            item.byte1    = u16u8_pkg::ASCII_F;
            item.byte2    = u16u8_pkg::ASCII_I;
        end else if (code_point == u16u8_pkg::LIG_FFL) begin
            item.byte0    = u16u8_pkg::ASCII_F;
            item.byte1    = u16u8_pkg::ASCII_F;
            item.byte2    = u16u8_pkg::ASCII_L;
        end else begin
            // Three-byte form, surrogates included
            item.byte0    = {u16u8_pkg::LEAD3_TAG, code_point[15:12]};
            item.byte1    = {u16u8_pkg::CONT_TAG, code_point[11:6]};
            item.byte2    = {u16u8_pkg::CONT_TAG, code_point[5:0]};
        end
    end

endmodule

[rtl/u16u8_queue.sv]
// Small FIFO of classified items between front and back end.
// Depends on u16u8_pkg.
module u16u8_queue #(
    parameter int DEPTH = 2
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  u16u8_pkg::u16u8_item_t push_item,
    output logic                   full,
    input  logic                   pop,
    output u16u8_pkg::u16u8_head_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    u16u8_pkg::u16u8_item_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full          = (count_reg == CNT_FULL);
    assign head.valid    = (count_reg != '0);
    assign head.item     = entry_reg[rd_ptr_reg];
    assign do_push       = push && !full;
    assign do_pop        = pop && head.valid;

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Payload storage, no reset
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[rtl/u16u8_back.sv]
// Back end: walks the queue head byte by byte into the output register.
// Depends on u16u8_pkg.
module u16u8_back (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  u16u8_pkg::u16u8_head_t head,
    output logic                   pop,
    output logic [7:0]             m_out_byte,
    output logic                   m_last,
    output logic                   m_valid,
    input  logic                   m_ready
);

    logic [1:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg, byte_next;
    logic       last_reg, last_next;
    logic       load;
    logic       at_last;

    // Output register is free when empty or being drained this cycle
    assign load    = !valid_reg || m_ready;
    assign at_last = (idx_reg == head.item.last_idx);
    assign pop     = load && head.valid && at_last;

    // Byte select and index advance
    always_comb begin
        case (idx_reg)
            2'd0:    byte_next = head.item.byte0;
            2'd1:    byte_next = head.item.byte1;
            default: byte_next = head.item.byte2;
        endcase
        last_next  = at_last;
        idx_next   = idx_reg;
        valid_next = valid_reg && !m_ready;
        if (load && head.valid) begin
            valid_next = 1'b1;
            idx_next   = at_last ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && head.valid) begin
            byte_reg <= byte_next;
            last_reg <= last_next;
        end
    end

    assign m_valid    = valid_reg;
    assign m_out_byte = byte_reg;
    assign m_last     = last_reg;

endmodule

[rtl/u16u8_checker.sv]
// Port-level checker for the UTF-16 unit to UTF-8 byte encoder, plus bind.
// Depends on utf16_unit_to_utf8_bytes port list only.
module u16u8_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [7:0]  m_out_byte,
    input logic        m_last
);

    // Tracks whether the next output byte opens a new sequence
    logic seq_start_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_start_reg <= 1'b1;
        end else if (m_valid && m_ready) begin
            seq_start_reg <= m_last;
        end
    end

    // Reset empties the output side
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

    // Reset leaves the queue empty, so the input side is open
    assert property (@(posedge aclk) !aresetn |=> s_ready)
        else $error("s_ready low after reset");

    // Stalled output byte holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte) && $stable(m_last))
        else $error("output changed while stalled");

    // A sequence never opens with a continuation byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        seq_start_reg && m_valid |-> m_out_byte[7:6] != 2'b10)
        else $error("sequence opens with continuation byte");

    // Multi-byte lead bytes are never the last byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        seq_start_reg && m_valid && (m_out_byte[7:5] == 3'b110 || m_out_byte[7:4] == 4'b1110)
        |-> !m_last)
        else $error("lead byte marked last");

endmodule

bind utf16_unit_to_utf8_bytes u16u8_checker u_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_out_byte   (m_out_byte),
    .m_last       (m_last)
);

[verif/utf16_unit_to_utf8_bytes_test.sv]
// Testbench for utf16_unit_to_utf8_bytes: directed table, then random code units.
// Checks every output byte and last flag against hand-written bytes or a model.
// Depends on u16u8_pkg and the utf16_unit_to_utf8_bytes RTL.
module utf16_unit_to_utf8_bytes_test;

    localparam int RANDOM_UNITS   = 400;
    localparam int QUIET_FROM     = 320;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int MAX_ROWS       = 32;
    localparam int EXP_DEPTH      = 2048;

    // Encoded form of one code unit: byte count and up to three bytes
    typedef struct packed {
        logic [1:0]      count;
        logic [0:2][7:0] bytes;
    } utf8_seq_t;

    // One expected output byte
    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } utf8_byte_t;

    // Directed row: code unit plus hand-written bytes (count 0 = use the model)
    typedef struct packed {
        logic [15:0] code;
        utf8_seq_t   typed;
    } unit_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [15:0] s_code_point;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_out_byte;
    logic        m_last;

    utf8_byte_t  pending_bytes[EXP_DEPTH];
    logic [10:0] exp_wr;
    logic [10:0] exp_rd;
    unit_row_t   directed_units[MAX_ROWS];
    logic [4:0]  row_count;
    utf8_seq_t   held_typed;
    bit          quiet_phase;
    int          error_count;
    int          stuck_cycles;

    utf16_unit_to_utf8_bytes uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_code_point (s_code_point),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_last       (m_last)
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Encoder model: UTF-8 bytes of one 16-bit unit, ligatures expanded
    function automatic utf8_seq_t encode_unit(input logic [15:0] cp);
        utf8_seq_t seq;
        seq = '0;
        if (cp < u16u8_pkg::ONE_BYTE_LIMIT) begin
            seq.count    = 2'd1;
            seq.bytes[0] = cp[7:0];
        end else if (cp < u16u8_pkg::TWO_BYTE_LIMIT) begin
            seq.count    = 2'd2;
            seq.bytes[0] = {u16u8_pkg::LEAD2_TAG, cp[10:6]};
            seq.bytes[1] = {u16u8_pkg::CONT_TAG, cp[5:0]};
        end else begin
            case (cp)
                u16u8_pkg::LIG_FF: begin
                    seq.count = 2'd2;
                    seq.bytes = {u16u8_pkg::ASCII_F, u16u8_pkg::ASCII_F, 8'h00};
                end
                u16u8_pkg::LIG_FI: begin
                    seq.count = 2'd2;
                    seq.bytes = {u16u8_pkg::ASCII_F, u16u8_pkg::ASCII_I, 8'h00};
                end
                u16u8_pkg::LIG_FL: begin
                    seq.count = 2'd2;
                    seq.bytes = {u16u8_pkg::ASCII_F, u16u8_pkg::ASCII_L, 8'h00};
                end
                u16u8_pkg::LIG_FFI: begin
                    seq.count = 2'd3;
                    seq.bytes = {u16u8_pkg::ASCII_F, u16u8_pkg::ASCII_F,
                                 u16u8_pkg::ASCII_I};
                end
                u16u8_pkg::LIG_FFL: begin
                    seq.count = 2'd3;
                    seq.bytes = {u16u8_pkg::ASCII_F, u16u8_pkg::ASCII_F,
                                 u16u8_pkg::ASCII_L};
                end
                default: begin
                    seq.count    = 2'd3;
                    seq.bytes[0] = {u16u8_pkg::LEAD3_TAG, cp[15:12]};
                    seq.bytes[1] = {u16u8_pkg::CONT_TAG, cp[11:6]};
                    seq.bytes[2] = {u16u8_pkg::CONT_TAG, cp[5:0]};
                end
            endcase
        end
        return seq;
    endfunction

    task automatic add_row(input logic [15:0] code, input logic [1:0] count,
                           input logic [7:0] b0, input logic [7:0] b1,
                           input logic [7:0] b2);
        unit_row_t row;
        row.code        = code;
        row.typed.count = count;
        row.typed.bytes = {b0, b1, b2};
        directed_units[row_count] = row;
        row_count = row_count + 5'd1;
    endtask

    // Present one unit at the falling edge and hold it until the transfer
    task automatic send_unit(input logic [15:0] code, input utf8_seq_t typed);
        int gap;
        if (!quiet_phase && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 12);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_code_point <= code;
        held_typed    = typed;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // Receiver: random stall bursts, always ready in the quiet phase
    initial begin
        int stall;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (!quiet_phase && $urandom_range(0, 7) == 0) begin
                stall = $urandom_range(1, 12);
                m_ready <= 1'b0;
                repeat (stall - 1) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Scoreboard: check output transfers, queue expected bytes on input transfers
    always @(posedge aclk) begin
        utf8_seq_t  seq;
        utf8_byte_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (exp_rd == exp_wr) begin
                    $error("unexpected byte %02h (last %0b)", m_out_byte, m_last);
                    error_count++;
                end else begin
                    want   = pending_bytes[exp_rd];
                    exp_rd = exp_rd + 11'd1;
                    if (m_out_byte !== want.value) begin
                        $error("out_byte: expected %02h, got %02h", want.value, m_out_byte);
                        error_count++;
                    end
                    if (m_last !== want.last) begin
                        $error("last: expected %0b, got %0b", want.last, m_last);
                        error_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                seq = (held_typed.count != 2'd0) ? held_typed : encode_unit(s_code_point);
                for (int k = 0; k < seq.count; k++) begin
                    want.value = seq.bytes[k[1:0]];
                    want.last  = (k == seq.count - 1);
                    pending_bytes[exp_wr] = want;
                    exp_wr = exp_wr + 11'd1;
                end
            end
        end
    end

    // Watchdog: too long without any transfer on either side
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                stuck_cycles <= 0;
            end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
                $display("utf16_unit_to_utf8_bytes_test: errors");
                $finish;
            end else begin
                stuck_cycles <= stuck_cycles + 1;
            end
        end
    end

    // Main sequence
    initial begin
        logic [15:0] unit_code;
        utf8_seq_t   no_typed;
        no_typed     = '0;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_code_point = 16'h0000;
        m_ready      = 1'b0;
        held_typed   = '0;
        quiet_phase  = 1'b0;
        error_count  = 0;
        stuck_cycles = 0;
        exp_wr       = '0;
        exp_rd       = '0;
        row_count    = '0;

        // Directed table: range edges, surrogates, every ligature and its neighbors
        add_row(16'h0000, 2'd1, 8'h00, 8'h00, 8'h00);
        add_row(16'h007F, 2'd1, 8'h7F, 8'h00, 8'h00);
        add_row(16'h0080, 2'd2, 8'hC2, 8'h80, 8'h00);
        add_row(16'h07FF, 2'd2, 8'hDF, 8'hBF, 8'h00);
        add_row(16'h0800, 2'd3, 8'hE0, 8'hA0, 8'h80);
        add_row(16'hFFFF, 2'd3, 8'hEF, 8'hBF, 8'hBF);
        add_row(16'hD800, 2'd3, 8'hED, 8'hA0, 8'h80);
        add_row(16'hDFFF, 2'd3, 8'hED, 8'hBF, 8'hBF);
        add_row(u16u8_pkg::LIG_FF,  2'd2, u16u8_pkg::ASCII_F, u16u8_pkg::ASCII_F, 8'h00);
        add_row(u16u8_pkg::LIG_FI,  2'd2, u16u8_pkg::ASCII_F, u16u8_pkg::ASCII_I, 8'h00);
        add_row(u16u8_pkg::LIG_FL,  2'd2, u16u8_pkg::ASCII_F, u16u8_pkg::ASCII_L, 8'h00);
        add_row(u16u8_pkg::LIG_FFI, 2'd3, u16u8_pkg::ASCII_F, u16u8_pkg::ASCII_F,
                u16u8_pkg::ASCII_I);
        add_row(u16u8_pkg::LIG_FFL, 2'd3, u16u8_pkg::ASCII_F, u16u8_pkg::ASCII_F,
                u16u8_pkg::ASCII_L);
        add_row(16'hFAFF, 2'd0, 8'h00, 8'h00, 8'h00);
        add_row(16'hFB05, 2'd0, 8'h00, 8'h00, 8'h00);
        add_row(16'hDBFF, 2'd0, 8'h00, 8'h00, 8'h00);
        add_row(16'hDC00, 2'd0, 8'h00, 8'h00, 8'h00);
        add_row(16'h0041, 2'd0, 8'h00, 8'h00, 8'h00);
        add_row(16'h00E9, 2'd0, 8'h00, 8'h00, 8'h00);
        add_row(16'h20AC, 2'd0, 8'h00, 8'h00, 8'h00);
        add_row(16'h5555, 2'd0, 8'h00, 8'h00, 8'h00);
        add_row(16'hAAAA, 2'd0, 8'h00, 8'h00, 8'h00);

        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < row_count; i++)
            send_unit(directed_units[i[4:0]].code, directed_units[i[4:0]].typed);

        // Random units, weighted toward each encoding class and the ligature window
        for (int n = 0; n < RANDOM_UNITS; n++) begin
            if (n == QUIET_FROM)
                quiet_phase = 1'b1;
            case ($urandom_range(0, 9))
                0, 1:    unit_code = 16'($urandom_range(16'h0000, 16'h007F));
                2, 3:    unit_code = 16'($urandom_range(16'h0080, 16'h07FF));
                4:       unit_code = 16'($urandom_range(16'hD800, 16'hDFFF));
                5:       unit_code = 16'($urandom_range(16'hFAFE, 16'hFB06));
                default: unit_code = 16'($urandom_range(16'h0000, 16'hFFFF));
            endcase
            send_unit(unit_code, no_typed);
        end
        s_valid <= 1'b0;

        // Drain, then give the block time to show any extra bytes
        while (exp_rd != exp_wr)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (error_count == 0) begin
            $display("utf16_unit_to_utf8_bytes_test: clean");
        end else begin
            $display("utf16_unit_to_utf8_bytes_test: errors");
        end
        $finish;
    end

endmodule
